[design/rsa_pkg.sv]
// Package: shared types, codes and constants for the stick arming block.
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

  // Pulse window in microseconds and the derived stick range in thousandths
  localparam int unsigned PulseW   = 12;
  localparam int unsigned StickW   = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [PulseW-1:0] PULSE_MIN = 12'd1000;
  localparam logic [PulseW-1:0] PULSE_MAX = 12'd2000;
  localparam logic [CountW-1:0] CNT_MAX   = '1;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_LOST_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STICK_LOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STICK_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_HIGH  = 3'd4;

  // Register reset values
  localparam logic [CountW-1:0] RST_LOST_TIMEOUT = 16'd300;
  localparam logic [StickW-1:0] RST_STICK_LOW    = 10'd100;
  localparam logic [StickW-1:0] RST_STICK_HIGH   = 10'd900;
  localparam logic [StickW-1:0] RST_CENTRE_LOW   = 10'd400;
  localparam logic [StickW-1:0] RST_CENTRE_HIGH  = 10'd600;

  // Stick classes as reported on stick_class
  typedef enum logic [1:0] {
    CLS_LOCK   = 2'd0,
    CLS_UNLOCK = 2'd1,
    CLS_CENTRE = 2'd2,
    CLS_NORMAL = 2'd3
  } stick_class_t;

  // Arming state codes as reported on arm_state
  localparam logic [1:0] ARM_LOCKED      = 2'd0;
  localparam logic [1:0] ARM_LOCK_PEND   = 2'd1;
  localparam logic [1:0] ARM_UNLOCKED    = 2'd2;
  localparam logic [1:0] ARM_UNLOCK_PEND = 2'd3;

  // Arming machine, one-hot
  typedef enum logic [3:0] {
    ST_LOCKED      = 4'b0001,
    ST_LOCK_PEND   = 4'b0010,
    ST_UNLOCKED    = 4'b0100,
    ST_UNLOCK_PEND = 4'b1000
  } arm_mode_t;

  // Stick thresholds from the configuration registers
  typedef struct packed {
    logic [StickW-1:0] stick_low;
    logic [StickW-1:0] stick_high;
    logic [StickW-1:0] centre_low;
    logic [StickW-1:0] centre_high;
  } thresh_t;

  // One result word
  typedef struct packed {
    logic [1:0]   arm_state;
    logic         lock_cmd;
    logic         unlock_cmd;
    logic         link_up;
    stick_class_t stick_class;
  } result_t;

  // Map a one-hot machine state to its reported code
  function automatic logic [1:0] mode_code(arm_mode_t m);
    logic [1:0] code;
    unique case (m)
      ST_LOCKED:      code = ARM_LOCKED;
      ST_LOCK_PEND:   code = ARM_LOCK_PEND;
      ST_UNLOCKED:    code = ARM_UNLOCKED;
      ST_UNLOCK_PEND: code = ARM_UNLOCK_PEND;
      default:        code = ARM_LOCKED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[design/rsa_classify.sv]
// Stick normalizer and classifier: clamp pulses, scale to thousandths, pick a class.
`timescale 1ns / 1ps
`default_nettype none

module rsa_classify (
  input  wire logic [rsa_pkg::PulseW-1:0] throttle_us,
  input  wire logic [rsa_pkg::PulseW-1:0] pitch_us,
  input  wire logic [rsa_pkg::PulseW-1:0] roll_us,
  input  wire rsa_pkg::thresh_t           thresh,
  output rsa_pkg::stick_class_t           cls
);

  // Clamp to the pulse window and remove the offset
  function automatic logic [rsa_pkg::StickW-1:0] norm(logic [rsa_pkg::PulseW-1:0] raw);
    logic [rsa_pkg::PulseW-1:0] v;
    logic [rsa_pkg::PulseW-1:0] d;
    v = raw;
    if (v > rsa_pkg::PULSE_MAX) v = rsa_pkg::PULSE_MAX;
    if (v < rsa_pkg::PULSE_MIN) v = rsa_pkg::PULSE_MIN;
    d = v - rsa_pkg::PULSE_MIN;
    return d[rsa_pkg::StickW-1:0];
  endfunction

  logic [rsa_pkg::StickW-1:0] thr;
  logic [rsa_pkg::StickW-1:0] pit;
  logic [rsa_pkg::StickW-1:0] rol;
  logic                       thr_low;
  logic                       pit_low;
  logic                       pit_high;
  logic                       pit_mid;
  logic                       rol_mid;

  assign thr = norm(throttle_us);
  assign pit = norm(pitch_us);
  assign rol = norm(roll_us);

  // Strict compares against the thresholds
  assign thr_low  = thr < thresh.stick_low;
  assign pit_low  = pit < thresh.stick_low;
  assign pit_high = pit > thresh.stick_high;
  assign pit_mid  = (pit > thresh.centre_low) && (pit < thresh.centre_high);
  assign rol_mid  = (rol > thresh.centre_low) && (rol < thresh.centre_high);

  // First matching rule wins
  always_comb begin
    priority if (thr_low && pit_low) begin
      cls = rsa_pkg::CLS_LOCK;
    end else if (thr_low && pit_high) begin
      cls = rsa_pkg::CLS_UNLOCK;
    end else if (thr_low && rol_mid && pit_mid) begin
      cls = rsa_pkg::CLS_CENTRE;
    end else begin
      cls = rsa_pkg::CLS_NORMAL;
    end
  end

endmodule

`default_nettype wire

[design/rsa_arm.sv]
// Arming machine, frame watchdog counter and last class, with the result they produce.
`timescale 1ns / 1ps
`default_nettype none

module rsa_arm (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic                       func,
  input  wire rsa_pkg::stick_class_t      cls,
  input  wire logic [rsa_pkg::CountW-1:0] lost_timeout_ms,
  output rsa_pkg::result_t                result
);

  rsa_pkg::arm_mode_t         mode;
  rsa_pkg::arm_mode_t         mode_next;
  logic [rsa_pkg::CountW-1:0] ms_since_frame;
  logic [rsa_pkg::CountW-1:0] ms_since_frame_next;
  rsa_pkg::stick_class_t      last_class;
  rsa_pkg::stick_class_t      last_class_next;
  logic                       lock_cmd;
  logic                       unlock_cmd;

  // Advance the machine on a frame; a tick only ages the counter
  always_comb begin
    mode_next           = mode;
    ms_since_frame_next = ms_since_frame;
    last_class_next     = last_class;
    lock_cmd            = 1'b0;
    unlock_cmd          = 1'b0;
    if (!func) begin
      last_class_next     = cls;
      ms_since_frame_next = '0;
      unique case (mode)
        rsa_pkg::ST_LOCKED: begin
          if (cls == rsa_pkg::CLS_UNLOCK) mode_next = rsa_pkg::ST_UNLOCK_PEND;
        end
        rsa_pkg::ST_LOCK_PEND: begin
          if (cls == rsa_pkg::CLS_CENTRE) begin
            mode_next = rsa_pkg::ST_LOCKED;
            lock_cmd  = 1'b1;
          end
        end
        rsa_pkg::ST_UNLOCKED: begin
          if (cls == rsa_pkg::CLS_LOCK) mode_next = rsa_pkg::ST_LOCK_PEND;
        end
        rsa_pkg::ST_UNLOCK_PEND: begin
          if (cls == rsa_pkg::CLS_CENTRE) begin
            mode_next  = rsa_pkg::ST_UNLOCKED;
            unlock_cmd = 1'b1;
          end
        end
        default: mode_next = rsa_pkg::ST_LOCKED;
      endcase
    end else if (ms_since_frame != rsa_pkg::CNT_MAX) begin
      ms_since_frame_next = ms_since_frame + 1'b1;
    end
  end

  // Drive the result word from the post-item state
  always_comb begin
    result.arm_state   = rsa_pkg::mode_code(mode_next);
    result.lock_cmd    = lock_cmd;
    result.unlock_cmd  = unlock_cmd;
    result.link_up     = ms_since_frame_next <= lost_timeout_ms;
    result.stick_class = last_class_next;
  end

  // Hold state between items
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= rsa_pkg::ST_LOCKED;
      ms_since_frame <= '0;
      last_class     <= rsa_pkg::CLS_NORMAL;
    end else if (step) begin
      mode           <= mode_next;
      ms_since_frame <= ms_since_frame_next;
      last_class     <= last_class_next;
    end
  end

endmodule

`default_nettype wire

[design/rc_stick_arming_fsm_core.sv]
// Top level of the RC stick arming block: input register, config registers, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------------
//  in       | in_valid / in_stall       | func, throttle_us, pitch_us, roll_us
//  out      | out_valid / out_stall     | arm_state, lock_cmd, unlock_cmd, link_up,
//           |                           | stick_class
//  cfg      | cfg_we, cfg_index         | cfg_data
//
//  One word per cycle sustained while out_stall is low; each accepted word goes through the
//  input register, then classify and state update into the result register.
//  Reset clears the arming machine to locked, the frame counter to zero, the last class
//  to normal, and loads the timeout and threshold registers with their defaults.
//  A stalled result holds in the output register while one more word waits in the input
//  register; in_stall rises only when both are full and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module rc_stick_arming_fsm_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         func,
  input  wire logic [rsa_pkg::PulseW-1:0]   throttle_us,
  input  wire logic [rsa_pkg::PulseW-1:0]   pitch_us,
  input  wire logic [rsa_pkg::PulseW-1:0]   roll_us,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        arm_state,
  output logic                              lock_cmd,
  output logic                              unlock_cmd,
  output logic                              link_up,
  output logic [1:0]                        stick_class,
  input  wire logic                         cfg_we,
  input  wire logic [rsa_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rsa_pkg::CfgDataW-1:0] cfg_data
);

  logic [rsa_pkg::CountW-1:0] lost_timeout_ms;
  rsa_pkg::thresh_t           thresh;

  logic                       s1_valid;
  logic                       s1_func;
  logic [rsa_pkg::PulseW-1:0] s1_throttle;
  logic [rsa_pkg::PulseW-1:0] s1_pitch;
  logic [rsa_pkg::PulseW-1:0] s1_roll;
  logic                       s1_fire;
  logic                       in_take;

  rsa_pkg::stick_class_t      cls;
  rsa_pkg::result_t           result;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_timeout_ms    <= rsa_pkg::RST_LOST_TIMEOUT;
      thresh.stick_low   <= rsa_pkg::RST_STICK_LOW;
      thresh.stick_high  <= rsa_pkg::RST_STICK_HIGH;
      thresh.centre_low  <= rsa_pkg::RST_CENTRE_LOW;
      thresh.centre_high <= rsa_pkg::RST_CENTRE_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsa_pkg::REG_LOST_TIMEOUT: lost_timeout_ms    <= cfg_data;
        rsa_pkg::REG_STICK_LOW:    thresh.stick_low   <= cfg_data[rsa_pkg::StickW-1:0];
        rsa_pkg::REG_STICK_HIGH:   thresh.stick_high  <= cfg_data[rsa_pkg::StickW-1:0];
        rsa_pkg::REG_CENTRE_LOW:   thresh.centre_low  <= cfg_data[rsa_pkg::StickW-1:0];
        rsa_pkg::REG_CENTRE_HIGH:  thresh.centre_high <= cfg_data[rsa_pkg::StickW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 advances whenever the result register is free or being taken
  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func     <= func;
      s1_throttle <= throttle_us;
      s1_pitch    <= pitch_us;
      s1_roll     <= roll_us;
    end
  end

  rsa_classify u_classify (
    .throttle_us (s1_throttle),
    .pitch_us    (s1_pitch),
    .roll_us     (s1_roll),
    .thresh      (thresh),
    .cls         (cls)
  );

  rsa_arm u_arm (
    .clk             (clk),
    .rst             (rst),
    .step            (s1_fire),
    .func            (s1_func),
    .cls             (cls),
    .lost_timeout_ms (lost_timeout_ms),
    .result          (result)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      arm_state   <= result.arm_state;
      lock_cmd    <= result.lock_cmd;
      unlock_cmd  <= result.unlock_cmd;
      link_up     <= result.link_up;
      stick_class <= result.stick_class;
    end
  end

endmodule

`default_nettype wire

[design/rsa_checker.sv]
// Port-level checker for the stick arming block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rsa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] arm_state,
  input wire logic       lock_cmd,
  input wire logic       unlock_cmd,
  input wire logic [1:0] stick_class
);

  // Never both commands in one word
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(lock_cmd && unlock_cmd))
    else $error("lock and unlock commands in the same word");

  // A lock command lands in locked and comes from a centred frame
  a_lock_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lock_cmd) |->
      (arm_state == rsa_pkg::ARM_LOCKED) && (stick_class == rsa_pkg::CLS_CENTRE))
    else $error("lock command without locked state and centre class");

  // An unlock command lands in unlocked and comes from a centred frame
  a_unlock_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unlock_cmd) |->
      (arm_state == rsa_pkg::ARM_UNLOCKED) && (stick_class == rsa_pkg::CLS_CENTRE))
    else $error("unlock command without unlocked state and centre class");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      out_valid && $stable(arm_state) && $stable(lock_cmd) && $stable(unlock_cmd)
      && $stable(stick_class))
    else $error("stalled result word changed");

endmodule

bind rc_stick_arming_fsm_core rsa_checker u_rsa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .arm_state   (arm_state),
  .lock_cmd    (lock_cmd),
  .unlock_cmd  (unlock_cmd),
  .stick_class (stick_class)
);

`default_nettype wire

[bench/rc_stick_arming_fsm_checker.sv]
// Checker for the stick arming block: predicts each result word and compares it field by field.
`timescale 1ns / 1ps

module rc_stick_arming_fsm_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         func,
  input  wire logic [rsa_pkg::PulseW-1:0]   throttle_us,
  input  wire logic [rsa_pkg::PulseW-1:0]   pitch_us,
  input  wire logic [rsa_pkg::PulseW-1:0]   roll_us,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [1:0]                   arm_state,
  input  wire logic                         lock_cmd,
  input  wire logic                         unlock_cmd,
  input  wire logic                         link_up,
  input  wire logic [1:0]                   stick_class,
  input  wire logic                         cfg_we,
  input  wire logic [rsa_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rsa_pkg::CfgDataW-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending
);

  import rsa_pkg::*;

  // Shadow copy of the registers and of the arming state
  logic [CountW-1:0] timeout_ms;
  logic [StickW-1:0] low_lim;
  logic [StickW-1:0] high_lim;
  logic [StickW-1:0] mid_lo;
  logic [StickW-1:0] mid_hi;
  logic [1:0]        arm_mode;
  logic [CountW-1:0] ms_idle;
  stick_class_t      frame_cls;

  // Result words still owed by the block, oldest first
  result_t due_words[$];

  // Clamp a pulse width to the window and express it in thousandths
  function automatic logic [StickW-1:0] thousandths(input logic [PulseW-1:0] us);
    logic [PulseW-1:0] c;
    c = us;
    if (c > PULSE_MAX) c = PULSE_MAX;
    if (c < PULSE_MIN) c = PULSE_MIN;
    c = c - PULSE_MIN;
    return c[StickW-1:0];
  endfunction

  function automatic logic centred(input logic [StickW-1:0] v);
    return (v > mid_lo) && (v < mid_hi);
  endfunction

  task automatic match_field(input string field, input logic [1:0] want,
                             input logic [1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [StickW-1:0] t;
    logic [StickW-1:0] p;
    logic [StickW-1:0] r;
    stick_class_t      cls;
    result_t           want;

    if (rst) begin
      timeout_ms = RST_LOST_TIMEOUT;
      low_lim    = RST_STICK_LOW;
      high_lim   = RST_STICK_HIGH;
      mid_lo     = RST_CENTRE_LOW;
      mid_hi     = RST_CENTRE_HIGH;
      arm_mode   = ARM_LOCKED;
      ms_idle    = '0;
      frame_cls  = CLS_NORMAL;
      due_words.delete();
    end else begin
      // Compare a delivered word against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = due_words.pop_front();
          match_field("arm_state", want.arm_state, arm_state);
          match_field("lock_cmd", {1'b0, want.lock_cmd}, {1'b0, lock_cmd});
          match_field("unlock_cmd", {1'b0, want.unlock_cmd}, {1'b0, unlock_cmd});
          match_field("link_up", {1'b0, want.link_up}, {1'b0, link_up});
          match_field("stick_class", want.stick_class, stick_class);
        end
      end

      // Track register writes; unknown indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_LOST_TIMEOUT: timeout_ms = cfg_data;
          REG_STICK_LOW:    low_lim    = cfg_data[StickW-1:0];
          REG_STICK_HIGH:   high_lim   = cfg_data[StickW-1:0];
          REG_CENTRE_LOW:   mid_lo     = cfg_data[StickW-1:0];
          REG_CENTRE_HIGH:  mid_hi     = cfg_data[StickW-1:0];
          default: ;
        endcase
      end

      // Advance the shadow machine on an accepted word
      if (in_valid && !in_stall) begin
        want.lock_cmd   = 1'b0;
        want.unlock_cmd = 1'b0;
        if (!func) begin
          t = thousandths(throttle_us);
          p = thousandths(pitch_us);
          r = thousandths(roll_us);
          if (t < low_lim && p < low_lim) cls = CLS_LOCK;
          else if (t < low_lim && p > high_lim) cls = CLS_UNLOCK;
          else if (t < low_lim && centred(r) && centred(p)) cls = CLS_CENTRE;
          else cls = CLS_NORMAL;
          frame_cls = cls;
          ms_idle   = '0;
          case (arm_mode)
            ARM_LOCKED: begin
              if (cls == CLS_UNLOCK) arm_mode = ARM_UNLOCK_PEND;
            end
            ARM_LOCK_PEND: begin
              if (cls == CLS_CENTRE) begin
                arm_mode      = ARM_LOCKED;
                want.lock_cmd = 1'b1;
              end
            end
            ARM_UNLOCKED: begin
              if (cls == CLS_LOCK) arm_mode = ARM_LOCK_PEND;
            end
            default: begin
              if (cls == CLS_CENTRE) begin
                arm_mode        = ARM_UNLOCKED;
                want.unlock_cmd = 1'b1;
              end
            end
          endcase
        end else if (ms_idle != CNT_MAX) begin
          ms_idle = ms_idle + 1'b1;
        end
        want.arm_state   = arm_mode;
        want.link_up     = (ms_idle <= timeout_ms);
        want.stick_class = frame_cls;
        due_words.push_back(want);
      end
    end
    pending = due_words.size();
  end

endmodule

[bench/tb_rc_stick_arming_fsm_core.sv]
// Testbench top for the stick arming block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_rc_stick_arming_fsm_core;

  import rsa_pkg::*;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                func        = 1'b0;
  logic [PulseW-1:0]   throttle_us = '0;
  logic [PulseW-1:0]   pitch_us    = '0;
  logic [PulseW-1:0]   roll_us     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [1:0]          arm_state;
  logic                lock_cmd;
  logic                unlock_cmd;
  logic                link_up;
  logic [1:0]          stick_class;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  int fail_count;
  int pending;

  // Idling rates in percent and the thresholds the stimulus aims at
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int timeout_cur    = 300;
  int low_lim        = 100;
  int high_lim       = 900;
  int mid_lo         = 400;
  int mid_hi         = 600;
  int words_sent     = 0;
  int gesture_step   = 0;

  rc_stick_arming_fsm_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .throttle_us (throttle_us),
    .pitch_us    (pitch_us),
    .roll_us     (roll_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .arm_state   (arm_state),
    .lock_cmd    (lock_cmd),
    .unlock_cmd  (unlock_cmd),
    .link_up     (link_up),
    .stick_class (stick_class),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  rc_stick_arming_fsm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .throttle_us (throttle_us),
    .pitch_us    (pitch_us),
    .roll_us     (roll_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .arm_state   (arm_state),
    .lock_cmd    (lock_cmd),
    .unlock_cmd  (unlock_cmd),
    .link_up     (link_up),
    .stick_class (stick_class),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #5 clk = ~clk;

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hard limit on run length
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic f, input logic [PulseW-1:0] t,
                           input logic [PulseW-1:0] p, input logic [PulseW-1:0] r);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    throttle_us <= t;
    pitch_us    <= p;
    roll_us     <= r;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, then junk to the unused indexes
  task automatic configure(input int to_ms, input int s_lo, input int s_hi,
                           input int c_lo, input int c_hi);
    drain();
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[CfgIdxW-1:0];
      case (k)
        REG_LOST_TIMEOUT: cfg_data <= to_ms[CfgDataW-1:0];
        REG_STICK_LOW:    cfg_data <= s_lo[CfgDataW-1:0];
        REG_STICK_HIGH:   cfg_data <= s_hi[CfgDataW-1:0];
        REG_CENTRE_LOW:   cfg_data <= c_lo[CfgDataW-1:0];
        REG_CENTRE_HIGH:  cfg_data <= c_hi[CfgDataW-1:0];
        default:          cfg_data <= CfgDataW'($urandom);
      endcase
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    timeout_cur = to_ms;
    low_lim     = s_lo;
    high_lim    = s_hi;
    mid_lo      = c_lo;
    mid_hi      = c_hi;
  endtask

  // Pulse width whose thousandths lie in lo..hi, sometimes past the window edges
  function automatic logic [PulseW-1:0] pulse_in(input int lo, input int hi);
    if (hi > 1000) hi = 1000;
    if (lo < 0) lo = 0;
    if (lo > hi) return PulseW'($urandom);
    if (lo == 0 && $urandom_range(3) == 0) return PulseW'($urandom_range(999, 0));
    if (hi == 1000 && $urandom_range(3) == 0) return PulseW'($urandom_range(4095, 2001));
    return PulseW'(1000 + $urandom_range(hi, lo));
  endfunction

  // Send a frame shaped to land in the given class
  task automatic send_frame(input stick_class_t aim);
    logic [PulseW-1:0] t;
    logic [PulseW-1:0] p;
    logic [PulseW-1:0] r;
    t = pulse_in(0, low_lim - 1);
    r = PulseW'($urandom);
    case (aim)
      CLS_LOCK:   p = pulse_in(0, low_lim - 1);
      CLS_UNLOCK: p = pulse_in(high_lim + 1, 1000);
      CLS_CENTRE: begin
        p = pulse_in(mid_lo + 1, mid_hi - 1);
        r = pulse_in(mid_lo + 1, mid_hi - 1);
      end
      default: begin
        t = pulse_in(low_lim, 1000);
        p = PulseW'($urandom);
      end
    endcase
    send_word(1'b0, t, p, r);
  endtask

  // Mostly arming gestures, with tick bursts, stray classes and raw noise
  task automatic random_item();
    int unsigned pick;
    int          n;
    pick = $urandom_range(99);
    if (pick < 14) begin
      n = (timeout_cur > 30) ? 30 : timeout_cur + 3;
      repeat ($urandom_range(n, 1))
        send_word(1'b1, PulseW'($urandom), PulseW'($urandom), PulseW'($urandom));
    end else if (pick < 24) begin
      send_word(1'b0, PulseW'($urandom), PulseW'($urandom), PulseW'($urandom));
    end else if (pick < 32) begin
      send_frame(stick_class_t'($urandom_range(3)));
    end else begin
      case (gesture_step)
        0:       send_frame(CLS_UNLOCK);
        2:       send_frame(CLS_LOCK);
        default: send_frame(CLS_CENTRE);
      endcase
      gesture_step = (gesture_step + 1) % 4;
    end
    if ($urandom_range(149) == 0) drain();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int to_ms,
                           input int s_lo, input int s_hi, input int c_lo,
                           input int c_hi, input int n_words);
    int goal;
    configure(to_ms, s_lo, s_hi, c_lo, c_hi);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_idle;
    goal = words_sent + n_words;
    while (words_sent < goal) random_item();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed sweep at reset thresholds
    send_word(1'b1, 12'h000, 12'h000, 12'h000);  // tick before any frame
    send_word(1'b0, 12'h000, 12'h000, 12'h000);  // below window: lock class
    send_word(1'b0, 12'h000, 12'hFFF, 12'h000);  // above window: unlock gesture
    send_word(1'b0, 12'd1000, 12'd1500, 12'd1500);  // centre: unlocked
    send_word(1'b0, 12'hFFF, 12'hFFF, 12'hFFF);  // normal
    send_word(1'b0, 12'd1099, 12'd1099, 12'd2000);  // lock gesture
    send_word(1'b0, 12'd1100, 12'd1000, 12'd1500);  // throttle on low threshold
    send_word(1'b0, 12'd1000, 12'd1400, 12'd1500);  // pitch on lower centre edge
    send_word(1'b0, 12'd1000, 12'd1600, 12'd1500);  // pitch on upper centre edge
    send_word(1'b0, 12'd1000, 12'd1500, 12'd1400);  // roll on lower centre edge
    send_word(1'b0, 12'd1050, 12'd1401, 12'd1599);  // centre: locked
    send_word(1'b0, 12'd1000, 12'd1900, 12'd1500);  // pitch on high threshold
    send_word(1'b0, 12'd1000, 12'd1901, 12'd1500);  // unlock gesture
    send_word(1'b0, 12'd1000, 12'd1000, 12'd1500);  // lock class while unlock pending
    send_word(1'b0, 12'd1000, 12'd1500, 12'd1500);  // unlocked
    send_word(1'b0, 12'd1000, 12'd1500, 12'd1500);  // centre while unlocked
    repeat (3) send_word(1'b1, 12'hFFF, 12'hFFF, 12'hFFF);

    // Zero timeout: one tick drops the link, a frame restores it
    configure(0, 100, 900, 400, 600);
    send_word(1'b1, 12'h000, 12'h000, 12'h000);
    send_word(1'b0, 12'hFFF, 12'h000, 12'h000);
    send_word(1'b1, 12'h000, 12'h000, 12'h000);

    // Thresholds past the stick range: every stick is low
    configure(300, 1023, 1023, 1023, 1023);
    send_word(1'b0, 12'd2000, 12'd2000, 12'd2000);
    send_word(1'b0, 12'hFFF, 12'h000, 12'hFFF);

    // Nothing is ever low
    configure(65535, 0, 0, 0, 1000);
    send_word(1'b0, 12'd0, 12'd2000, 12'd1500);

    // Widest bands
    configure(65535, 1, 999, 0, 1000);
    send_word(1'b0, 12'd1000, 12'hFFF, 12'd0);
    send_word(1'b0, 12'd1000, 12'd1001, 12'd1999);
    send_word(1'b0, 12'd1001, 12'd1500, 12'd1500);
    send_word(1'b0, 12'd1000, 12'd1000, 12'd1500);

    // Timeout just under the counter limit
    configure(65534, 100, 900, 400, 600);
    send_word(1'b1, 12'h000, 12'h000, 12'h000);

    // Random phases at each idling mix
    run_phase(0, 0, 300, 100, 900, 400, 600, 200);
    run_phase(71, 0, 4, 150, 850, 350, 650, 200);
    run_phase(0, 71, $urandom_range(20), $urandom_range(300, 20), $urandom_range(980, 700),
              $urandom_range(450, 250), $urandom_range(750, 550), 200);
    run_phase(20, 20, 1, 1, 999, 0, 1000, 200);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rsa_pkg.sv
design/rsa_classify.sv
design/rsa_arm.sv
design/rc_stick_arming_fsm_core.sv
design/rsa_checker.sv
bench/rc_stick_arming_fsm_checker.sv
bench/tb_rc_stick_arming_fsm_core.sv
